>>> rtl/smvs_pkg.sv
// Shared widths, codes and types of the sample mean / variance / deviation block.
package smvs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 33;
    localparam int SQSUM_W    = 47;
    localparam int MEAN_W     = 24;
    localparam int VAR_W      = 40;
    localparam int STD_W      = 24;
    localparam int STATUS_W   = 2;
    localparam int FRAC_W     = 8;

    // Shared arithmetic unit
    localparam int WORD_W     = 64;
    localparam int MUL_W      = 32;
    localparam int DIV_W      = 32;
    localparam int QUO_W      = 48;
    localparam int ROOT_W     = 24;
    localparam int SQ_REM_W   = 26;
    localparam int CNT_W      = $clog2(QUO_W + 1);

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(65535);

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SUB,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_NN,
        S_P1,
        S_P2,
        S_DIFF,
        S_VDIV,
        S_SQRT,
        S_LOAD
    } seq_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic signed [SUM_W-1:0]  sum;
        logic [SQSUM_W-1:0]       sumsq;
        logic                     ovf;
    } acc_view_t;

    typedef struct packed {
        logic                start;
        alu_op_t             op;
        logic [WORD_W-1:0]   opa;
        logic [WORD_W-1:0]   opb;
    } alu_req_t;

    typedef struct packed {
        logic                done;
        logic [WORD_W-1:0]   result;
    } alu_rsp_t;

    typedef struct packed {
        logic [MEAN_W-1:0]   mean_q8;
        logic [VAR_W-1:0]    variance_q8;
        logic [STD_W-1:0]    std_dev_q8;
        logic [COUNT_W-1:0]  sample_count;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

>>> rtl/smvs_ifs.sv
// Valid/ready channel interfaces for sample words and result words.
interface smvs_in_if;
    import smvs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface smvs_out_if;
    import smvs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MEAN_W-1:0]   mean_q8;
    logic [VAR_W-1:0]           variance_q8;
    logic [STD_W-1:0]           std_dev_q8;
    logic [COUNT_W-1:0]         sample_count;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output mean_q8, output variance_q8, output std_dev_q8,
                    output sample_count, output status, input ready);
    modport sink   (input valid, input mean_q8, input variance_q8, input std_dev_q8,
                    input sample_count, input status, output ready);
endinterface

>>> rtl/smvs_accum.sv
// Running count, sum and sum of squares of the current group.
module smvs_accum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic signed [smvs_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 clear,
    output smvs_pkg::acc_view_t                  view
);
    import smvs_pkg::*;

    logic [COUNT_W-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [SQSUM_W-1:0]          sumsq_reg, sumsq_next;
    logic                        ovf_reg, ovf_next;
    logic signed [2*SAMPLE_W-1:0] square;

    always_comb
    begin
        square     = sample * sample;
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        ovf_next   = ovf_reg;
        if (clear)
        begin
            count_next = '0;
            sum_next   = '0;
            sumsq_next = '0;
            ovf_next   = 1'b0;
        end
        else if (take)
        begin
            // drop samples past the count limit, remember that it happened
            if (count_reg == MAX_COUNT)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(sample);
                sumsq_next = sumsq_reg + SQSUM_W'($unsigned(square));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign view.count = count_reg;
    assign view.sum   = sum_reg;
    assign view.sumsq = sumsq_reg;
    assign view.ovf   = ovf_reg;

endmodule

>>> rtl/smvs_alu.sv
// Shared iterative unit: shift-add multiply, subtract, restoring divide, integer square root.
module smvs_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  smvs_pkg::alu_req_t req,
    output smvs_pkg::alu_rsp_t rsp
);
    import smvs_pkg::*;

    localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(MUL_W);
    localparam logic [CNT_W-1:0] SUB_STEPS  = CNT_W'(1);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(QUO_W);
    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ROOT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    alu_op_t             op_reg, op_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   opd_reg, opd_next;
    logic [WORD_W-1:0]   sh_reg, sh_next;

    logic [WORD_W-1:0]   add_a, add_b;
    logic                add_cin;
    logic [WORD_W:0]     add_sum;
    logic                ge;
    logic [DIV_W:0]      div_rs;
    logic [SQ_REM_W+1:0] sq_rs;
    logic [SQ_REM_W-1:0] sq_trial;

    // one adder serves every operation; its carry out is the compare result
    always_comb
    begin
        div_rs   = {acc_reg[DIV_W-1:0], sh_reg[QUO_W-1]};
        sq_rs    = {acc_reg[SQ_REM_W-1:0], sh_reg[QUO_W-1 -: 2]};
        sq_trial = {opd_reg[ROOT_W-1:0], 2'b01};
        case (op_reg)
            ALU_MUL:
            begin
                add_a   = {acc_reg[WORD_W-2:0], 1'b0};
                add_b   = sh_reg[WORD_W-1] ? opd_reg : '0;
                add_cin = 1'b0;
            end
            ALU_SUB:
            begin
                add_a   = acc_reg;
                add_b   = ~opd_reg;
                add_cin = 1'b1;
            end
            ALU_DIV:
            begin
                add_a   = WORD_W'(div_rs);
                add_b   = ~WORD_W'(opd_reg[DIV_W-1:0]);
                add_cin = 1'b1;
            end
            ALU_SQRT:
            begin
                add_a   = WORD_W'(sq_rs);
                add_b   = ~WORD_W'(sq_trial);
                add_cin = 1'b1;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + (WORD_W + 1)'(add_cin);
        ge      = add_sum[WORD_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        opd_next  = opd_reg;
        sh_next   = sh_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                case (req.op)
                    ALU_MUL:
                    begin
                        cnt_next = MUL_STEPS;
                        acc_next = '0;
                        opd_next = req.opa;
                        sh_next  = {req.opb[MUL_W-1:0], {(WORD_W-MUL_W){1'b0}}};
                    end
                    ALU_SUB:
                    begin
                        cnt_next = SUB_STEPS;
                        acc_next = req.opa;
                        opd_next = req.opb;
                    end
                    ALU_DIV:
                    begin
                        // dividend is opa scaled by 2^16, quotient fits QUO_W bits
                        cnt_next = DIV_STEPS;
                        acc_next = WORD_W'(req.opa[WORD_W-1:DIV_W]);
                        opd_next = WORD_W'(req.opb[DIV_W-1:0]);
                        sh_next  = WORD_W'({req.opa[DIV_W-1:0], {(QUO_W-DIV_W){1'b0}}});
                    end
                    ALU_SQRT:
                    begin
                        cnt_next = SQRT_STEPS;
                        acc_next = '0;
                        opd_next = '0;
                        sh_next  = WORD_W'(req.opa[QUO_W-1:0]);
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            case (op_reg)
                ALU_MUL:
                begin
                    acc_next = add_sum[WORD_W-1:0];
                    sh_next  = {sh_reg[WORD_W-2:0], 1'b0};
                end
                ALU_SUB:
                begin
                    acc_next = add_sum[WORD_W-1:0];
                end
                ALU_DIV:
                begin
                    acc_next = ge ? WORD_W'(add_sum[DIV_W-1:0]) : WORD_W'(div_rs[DIV_W-1:0]);
                    sh_next  = WORD_W'({sh_reg[QUO_W-2:0], ge});
                end
                ALU_SQRT:
                begin
                    acc_next = ge ? WORD_W'(add_sum[SQ_REM_W-1:0])
                                  : WORD_W'(sq_rs[SQ_REM_W-1:0]);
                    sh_next  = WORD_W'({sh_reg[QUO_W-3:0], 2'b00});
                    opd_next = WORD_W'({opd_reg[ROOT_W-2:0], ge});
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opd_reg <= opd_next;
        sh_reg  <= sh_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        case (op_reg)
            ALU_DIV:  rsp.result = WORD_W'(sh_reg[QUO_W-1:0]);
            ALU_SQRT: rsp.result = WORD_W'(opd_reg[ROOT_W-1:0]);
            default:  rsp.result = acc_reg;
        endcase
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg && !done_reg)
        else $error("operation issued while the unit is still working");

    a_div_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        req.start && (req.op == ALU_DIV) |-> req.opa[WORD_W-1:DIV_W] < req.opb[DIV_W-1:0])
        else $error("divide issued whose quotient overflows the quotient register");

endmodule

>>> rtl/smvs_seq.sv
// Sequencer that walks the end-of-group math through the shared unit.
module smvs_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                launch,
    input  smvs_pkg::acc_view_t view,
    input  logic                load_ok,
    output logic                busy,
    output logic                load,
    output smvs_pkg::alu_req_t  req,
    input  smvs_pkg::alu_rsp_t  rsp,
    output smvs_pkg::result_t   res
);
    import smvs_pkg::*;

    seq_state_t          state_reg, state_next;
    logic                issue_reg, issue_next;
    logic [MEAN_W-1:0]   mean_reg, mean_next;
    logic [VAR_W-1:0]    var_reg, var_next;
    logic [STD_W-1:0]    std_reg, std_next;
    logic [DIV_W-1:0]    m_reg, m_next;
    logic [WORD_W-1:0]   w_reg, w_next;

    logic [SUM_W-1:0]    abs_sum;
    logic [MEAN_W-1:0]   mean_mag;
    logic                single;

    always_comb
    begin
        abs_sum  = view.sum[SUM_W-1] ? (~view.sum + 1'b1) : view.sum;
        mean_mag = rsp.result[2*FRAC_W-FRAC_W +: MEAN_W];
        single   = (view.count[COUNT_W-1:1] == '0);

        state_next = state_reg;
        mean_next  = mean_reg;
        var_next   = var_reg;
        std_next   = std_reg;
        m_next     = m_reg;
        w_next     = w_reg;
        load       = 1'b0;
        req.start  = issue_reg;
        req.op     = ALU_MUL;
        req.opa    = '0;
        req.opb    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (launch)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                // |sum| * 2^16 / n, keep the Q8 part, restore the sign
                req.op  = ALU_DIV;
                req.opa = WORD_W'(abs_sum);
                req.opb = WORD_W'(view.count);
                if (rsp.done)
                begin
                    mean_next  = view.sum[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;
                    state_next = single ? S_LOAD : S_NN;
                end
            end
            S_NN:
            begin
                req.op  = ALU_MUL;
                req.opa = WORD_W'(view.count);
                req.opb = WORD_W'(view.count - 1'b1);
                if (rsp.done)
                begin
                    m_next     = rsp.result[DIV_W-1:0];
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                req.op  = ALU_MUL;
                req.opa = WORD_W'(view.sumsq);
                req.opb = WORD_W'(view.count);
                if (rsp.done)
                begin
                    w_next     = rsp.result;
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                req.op  = ALU_MUL;
                req.opa = WORD_W'(abs_sum);
                req.opb = WORD_W'(abs_sum);
                if (rsp.done)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // square of the sum still sits in the unit's accumulator
                req.op  = ALU_SUB;
                req.opa = w_reg;
                req.opb = rsp.result;
                if (rsp.done)
                begin
                    w_next     = rsp.result;
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                req.op  = ALU_DIV;
                req.opa = w_reg;
                req.opb = WORD_W'(m_reg);
                if (rsp.done)
                begin
                    var_next   = rsp.result[FRAC_W +: VAR_W];
                    w_next     = rsp.result;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                req.op  = ALU_SQRT;
                req.opa = w_reg;
                if (rsp.done)
                begin
                    std_next   = rsp.result[STD_W-1:0];
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                load = load_ok;
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        issue_next = (state_next != state_reg) && (state_next != S_IDLE)
                     && (state_next != S_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        var_reg  <= var_next;
        std_reg  <= std_next;
        m_reg    <= m_next;
        w_reg    <= w_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        res.mean_q8      = mean_reg;
        res.variance_q8  = single ? '0 : var_reg;
        res.std_dev_q8   = single ? '0 : std_reg;
        res.sample_count = view.count;
        if (view.ovf)
        begin
            res.status = STATUS_OVERFLOW;
        end
        else if (single)
        begin
            res.status = STATUS_SINGLE;
        end
        else
        begin
            res.status = STATUS_OK;
        end
    end

    a_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg != S_IDLE) && (state_reg != S_LOAD))
        else $error("unit finished with no step waiting on it");

endmodule

>>> rtl/sample_mean_variance_stddev.sv
// Top level: group mean, sample variance and standard deviation over a valid/ready stream.
// Samples that do not end a group are taken one per cycle while the sequencer is idle.
// A group's last word starts the end-of-group math (divide and load only for a single-sample group):
// divide, three multiplies, subtract, divide, square root, then load,
// all through one shared iterative unit; the input is held off until the result is loaded.
// Reset (rst_n, async, active low) clears the accumulators, the sequencer state and the output valid flag.
module sample_mean_variance_stddev (
    input  logic        clk,
    input  logic        rst_n,
    smvs_in_if.sink     samples,
    smvs_out_if.source  results
);
    import smvs_pkg::*;

    logic        busy;
    logic        load;
    logic        load_ok;
    logic        take;
    logic        launch;
    acc_view_t   view;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    result_t     res;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    // Take a word whenever the sequencer is idle; the result register keeps its own
    // handshake, but a full one stalls the sequencer in its load state, which holds off input.
    assign samples.ready = !busy;
    assign take          = samples.valid && samples.ready;
    assign launch        = take && samples.last;

    // Load the result register when it is empty or being drained this cycle.
    assign load_ok = !out_valid_reg || results.ready;

    smvs_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .sample (samples.sample),
        .clear  (load),
        .view   (view)
    );

    smvs_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (launch),
        .view    (view),
        .load_ok (load_ok),
        .busy    (busy),
        .load    (load),
        .req     (alu_req),
        .rsp     (alu_rsp),
        .res     (res)
    );

    smvs_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // Output register: hold the word until the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.mean_q8      = $signed(out_reg.mean_q8);
    assign results.variance_q8  = out_reg.variance_q8;
    assign results.std_dev_q8   = out_reg.std_dev_q8;
    assign results.sample_count = out_reg.sample_count;
    assign results.status       = out_reg.status;

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load))
        else $error("result word appeared without a load from the sequencer");

endmodule
